// ===== src/complex_block_decimator_defines.svh =====
// ----------------------------------------------------------------------------
// Complex block decimator assertion macros
// Shared assertion shorthands for the decimator checker.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_BLOCK_DECIMATOR_DEFINES_SVH
`define COMPLEX_BLOCK_DECIMATOR_DEFINES_SVH

// Condition now implies consequence in the next cycle, outside reset.
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

// Condition implies consequence in the same cycle, outside reset.
`define CBD_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication that is also checked while reset is held.
`define CBD_ASSERT_ALWAYS_NEXT(lbl, clk, ante, cons, msg) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/cbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Complex block decimator package
// Widths, register indexes, command codes and the result word type.
// ----------------------------------------------------------------------------
`default_nettype none

package cbd_pkg;

    localparam int MAX_FACTOR = 64;
    localparam int PH_W       = $clog2(MAX_FACTOR);
    localparam int FCT_W      = $clog2(MAX_FACTOR + 1);

    localparam int SAMP_W    = 16;
    localparam int COEF_W    = 18;
    localparam int CIDX_W    = 6;
    localparam int PROD_W    = SAMP_W + COEF_W;
    localparam int ACC_W     = 40;
    localparam int OUT_W     = 32;
    localparam int DECIM_W   = 7;
    localparam int SHIFT_W   = 6;
    localparam int SHIFT_MAX = 40;

    localparam int S_TDATA_W = 56;
    localparam int M_TDATA_W = 96;

    localparam int CFG_AW = 1;
    localparam int CFG_DW = 7;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    typedef enum logic [CFG_AW-1:0] {
        REG_DECIM = 1'b0,
        REG_SHIFT = 1'b1
    } t_cfg_reg;

    typedef enum logic {
        CMD_SAMPLE = 1'b0,
        CMD_COEF   = 1'b1
    } t_cmd;

    typedef struct packed {
        logic             res;
        logic             term;
        logic             last;
        logic [OUT_W-1:0] index;
    } t_stage;

    typedef struct packed {
        logic             end_flag;
        logic [OUT_W-1:0] out_index;
        logic [OUT_W-1:0] out_q;
        logic [OUT_W-1:0] out_i;
    } t_result;

endpackage

`default_nettype wire

// ===== src/complex_block_decimator.sv =====
// ----------------------------------------------------------------------------
// Complex block decimator
// Weights blocks of complex samples by a coefficient table and sums each block.
// ----------------------------------------------------------------------------
// The block takes one word per clock while s_axis_tready is high and gives one
// result word per finished block or terminating sample. A sample passes a
// coefficient RAM read, a registered 16x18 multiply, the 40-bit accumulate and
// a shift-and-saturate stage before its result is pushed into the output queue.
// The single read port of the coefficient RAM, one entry per sample, sets the
// rate of one word per cycle. Results wait in an eight-word output queue;
// s_axis_tready stays high as long as the queue plus the results still in the
// pipeline leave room, so the input only stalls when the output side has been
// held off. Coefficients are loaded through command words (tuser high); the
// user must load them before samples are sent, as the block does not enforce
// this, and there is no clearing pass after reset.
`default_nettype none

module complex_block_decimator
    import cbd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Configuration write port
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_AW-1:0]    i_cfg_addr,
    input  wire logic [CFG_DW-1:0]    i_cfg_wdata,
    // Input stream
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    // sample_i[15:0], sample_q[31:16], coef_index[37:32], coef_value[55:38]
    input  wire logic [S_TDATA_W-1:0] s_axis_tdata,
    // cmd
    input  wire logic                 s_axis_tuser,
    // terminating
    input  wire logic                 s_axis_tlast,
    // Output stream
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    // out_i[31:0], out_q[63:32], out_index[95:64]
    output logic      [M_TDATA_W-1:0] m_axis_tdata,
    // end_flag
    output logic                      m_axis_tlast
);

    // Configuration registers
    logic [DECIM_W-1:0] r_decim;
    logic [SHIFT_W-1:0] r_out_shift;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decim     <= DECIM_W'(1);
            r_out_shift <= '0;
        end else if (i_cfg_we) begin
            case (t_cfg_reg'(i_cfg_addr))
                REG_DECIM: r_decim     <= i_cfg_wdata[DECIM_W-1:0];
                REG_SHIFT: r_out_shift <= i_cfg_wdata[SHIFT_W-1:0];
                default:   ;
            endcase
        end
    end

    // Input field unpacking
    logic signed [SAMP_W-1:0] w_in_i;
    logic signed [SAMP_W-1:0] w_in_q;
    logic        [CIDX_W-1:0] w_in_cidx;
    logic        [COEF_W-1:0] w_in_coef;
    logic                     w_acc;
    logic                     w_is_coef;
    logic                     w_is_term;
    logic                     w_is_samp;

    assign w_in_i    = s_axis_tdata[15:0];
    assign w_in_q    = s_axis_tdata[31:16];
    assign w_in_cidx = s_axis_tdata[37:32];
    assign w_in_coef = s_axis_tdata[55:38];

    assign w_acc     = s_axis_tvalid && s_axis_tready;
    assign w_is_coef = w_acc && (t_cmd'(s_axis_tuser) == CMD_COEF);
    assign w_is_term = w_acc && (t_cmd'(s_axis_tuser) == CMD_SAMPLE) && s_axis_tlast;
    assign w_is_samp = w_acc && (t_cmd'(s_axis_tuser) == CMD_SAMPLE) && !s_axis_tlast;

    // Block phase and output count live at the intake so the RAM address
    // is ready in the cycle a sample is taken.
    logic [PH_W-1:0]  r_phase;
    logic [PH_W-1:0]  n_phase;
    logic [OUT_W-1:0] r_out_count;
    logic [OUT_W-1:0] n_out_count;
    logic [FCT_W-1:0] w_factor;
    logic             w_last;

    always_comb begin
        if (r_decim == '0) begin
            w_factor = FCT_W'(1);
        end else if (32'(r_decim) > 32'(MAX_FACTOR)) begin
            w_factor = FCT_W'(MAX_FACTOR);
        end else begin
            w_factor = FCT_W'(r_decim);
        end
    end

    // A lowered factor can leave the phase beyond the block end: ">=" ends it.
    assign w_last = (FCT_W'(r_phase) + FCT_W'(1)) >= w_factor;

    always_comb begin
        n_phase     = r_phase;
        n_out_count = r_out_count;
        if (w_is_term) begin
            n_phase = '0;
        end else if (w_is_samp) begin
            if (w_last) begin
                n_phase     = '0;
                n_out_count = r_out_count + OUT_W'(1);
            end else begin
                n_phase = r_phase + PH_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= '0;
            r_out_count <= '0;
        end else begin
            r_phase     <= n_phase;
            r_out_count <= n_out_count;
        end
    end

    // Coefficient table
    logic             w_coef_we;
    logic [COEF_W-1:0] w_coef_rd;

    assign w_coef_we = w_is_coef && (32'(w_in_cidx) < 32'(MAX_FACTOR));

    cbd_ram #(
        .WIDTH (COEF_W),
        .DEPTH (MAX_FACTOR)
    ) u_coef_ram (
        .i_clk   (i_clk),
        .i_we    (w_coef_we),
        .i_waddr (PH_W'(w_in_cidx)),
        .i_wdata (w_in_coef),
        .i_re    (w_is_samp),
        .i_raddr (r_phase),
        .o_rdata (w_coef_rd)
    );

    // Stage 1: coefficient arrives from the RAM
    logic                     r_s1_v;
    t_stage                   r_s1;
    logic signed [SAMP_W-1:0] r_s1_i;
    logic signed [SAMP_W-1:0] r_s1_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
        end else begin
            r_s1_v <= w_is_samp || w_is_term;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1.term  <= w_is_term;
        r_s1.last  <= w_last;
        r_s1.res   <= w_is_term || (w_is_samp && w_last);
        r_s1.index <= r_out_count;
        r_s1_i     <= w_in_i;
        r_s1_q     <= w_in_q;
    end

    // Stage 2: products
    logic                     r_s2_v;
    t_stage                   r_s2;
    logic signed [SAMP_W-1:0] r_s2_i;
    logic signed [SAMP_W-1:0] r_s2_q;
    logic signed [PROD_W-1:0] r_s2_pi;
    logic signed [PROD_W-1:0] r_s2_pq;
    logic signed [COEF_W-1:0] w_coef_s;

    assign w_coef_s = w_coef_rd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_v <= 1'b0;
        end else begin
            r_s2_v <= r_s1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2    <= r_s1;
        r_s2_i  <= r_s1_i;
        r_s2_q  <= r_s1_q;
        r_s2_pi <= r_s1_i * w_coef_s;
        r_s2_pq <= r_s1_q * w_coef_s;
    end

    // Stage 3: accumulate
    logic signed [ACC_W-1:0] r_acc_i;
    logic signed [ACC_W-1:0] r_acc_q;
    logic signed [ACC_W-1:0] w_sum_i;
    logic signed [ACC_W-1:0] w_sum_q;
    logic                    r_s3_v;
    t_stage                  r_s3;
    logic signed [ACC_W-1:0] r_s3_i;
    logic signed [ACC_W-1:0] r_s3_q;

    assign w_sum_i = r_acc_i + ACC_W'(r_s2_pi);
    assign w_sum_q = r_acc_q + ACC_W'(r_s2_pq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
            r_s3_v  <= 1'b0;
        end else begin
            r_s3_v <= r_s2_v;
            if (r_s2_v) begin
                if (r_s2.term || r_s2.last) begin
                    r_acc_i <= '0;
                    r_acc_q <= '0;
                end else begin
                    r_acc_i <= w_sum_i;
                    r_acc_q <= w_sum_q;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3 <= r_s2;
        if (r_s2.term) begin
            r_s3_i <= ACC_W'(r_s2_i);
            r_s3_q <= ACC_W'(r_s2_q);
        end else begin
            r_s3_i <= w_sum_i;
            r_s3_q <= w_sum_q;
        end
    end

    // Stage 4: shift, saturate and push into the output queue
    function automatic logic [OUT_W-1:0] shift_sat(
        input logic signed [ACC_W-1:0] acc,
        input logic [SHIFT_W-1:0]      sh
    );
        logic signed [ACC_W-1:0] v;
        logic [SHIFT_W-1:0]      s;
        logic [OUT_W-1:0]        r;
        s = (32'(sh) > SHIFT_MAX) ? SHIFT_W'(SHIFT_MAX) : sh;
        v = acc >>> s;
        if (v[ACC_W-1:OUT_W-1] == '0 || v[ACC_W-1:OUT_W-1] == '1) begin
            r = v[OUT_W-1:0];
        end else if (v[ACC_W-1]) begin
            r = {1'b1, {(OUT_W-1){1'b0}}};
        end else begin
            r = {1'b0, {(OUT_W-1){1'b1}}};
        end
        return r;
    endfunction

    t_result w_res;
    logic    w_push;

    always_comb begin
        w_res.end_flag  = r_s3.term;
        w_res.out_index = r_s3.index;
        if (r_s3.term) begin
            w_res.out_i = r_s3_i[OUT_W-1:0];
            w_res.out_q = r_s3_q[OUT_W-1:0];
        end else begin
            w_res.out_i = shift_sat(r_s3_i, r_out_shift);
            w_res.out_q = shift_sat(r_s3_q, r_out_shift);
        end
    end

    assign w_push = r_s3_v && r_s3.res;

    // Output queue
    t_result              r_fifo [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   r_wr_ptr;
    logic [FIFO_AW-1:0]   r_rd_ptr;
    logic [FIFO_CW-1:0]   r_count;
    logic                 w_pop;
    logic [FIFO_CW+1-1:0] w_occupancy;
    t_result              w_head;

    assign w_pop = m_axis_tvalid && m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fifo[r_wr_ptr] <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= r_wr_ptr + FIFO_AW'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + FIFO_AW'(1);
            end
            r_count <= r_count + FIFO_CW'(w_push) - FIFO_CW'(w_pop);
        end
    end

    // Every result still in the pipeline has a queue slot reserved for it.
    assign w_occupancy = (FIFO_CW+1)'(r_count)
                       + (FIFO_CW+1)'(r_s1_v && r_s1.res)
                       + (FIFO_CW+1)'(r_s2_v && r_s2.res)
                       + (FIFO_CW+1)'(r_s3_v && r_s3.res);

    assign s_axis_tready = i_rst_n && (w_occupancy < (FIFO_CW+1)'(FIFO_DEPTH));

    assign w_head        = r_fifo[r_rd_ptr];
    assign m_axis_tvalid = (r_count != '0);
    assign m_axis_tdata  = {w_head.out_index, w_head.out_q, w_head.out_i};
    assign m_axis_tlast  = w_head.end_flag;

endmodule

`default_nettype wire

// ===== src/cbd_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module cbd_ram #(
    parameter int WIDTH = 18,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== src/cbd_checker.sv =====
// ----------------------------------------------------------------------------
// Complex block decimator checker
// Port-level assertions on the output stream, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "complex_block_decimator_defines.svh"

module cbd_checker
    import cbd_pkg::*;
(
    input wire logic                 i_clk,
    input wire logic                 i_rst_n,
    input wire logic                 i_cfg_we,
    input wire logic [CFG_AW-1:0]    i_cfg_addr,
    input wire logic [CFG_DW-1:0]    i_cfg_wdata,
    input wire logic                 s_axis_tvalid,
    input wire logic                 s_axis_tready,
    input wire logic [S_TDATA_W-1:0] s_axis_tdata,
    input wire logic                 s_axis_tuser,
    input wire logic                 s_axis_tlast,
    input wire logic                 m_axis_tvalid,
    input wire logic                 m_axis_tready,
    input wire logic [M_TDATA_W-1:0] m_axis_tdata,
    input wire logic                 m_axis_tlast
);

    logic w_stalled;
    logic w_end_word;

    assign w_stalled  = m_axis_tvalid && !m_axis_tready;
    assign w_end_word = m_axis_tvalid && m_axis_tlast;

    // A stalled output word stays offered.
    `CBD_ASSERT_NEXT(a_valid_held, i_clk, i_rst_n, w_stalled, m_axis_tvalid, "output word dropped while stalled")

    // A stalled output word keeps its contents.
    `CBD_ASSERT_NEXT(a_data_held, i_clk, i_rst_n, w_stalled, $stable(m_axis_tdata) && $stable(m_axis_tlast), "output word changed while stalled")

    // The queue is empty right after reset.
    `CBD_ASSERT_ALWAYS_NEXT(a_reset_empty, i_clk, !i_rst_n, !m_axis_tvalid, "output word offered after reset")

    // A passed-through terminating word carries a sign-extended 16-bit sample.
    `CBD_ASSERT_SAME(a_end_raw, i_clk, i_rst_n, w_end_word, (m_axis_tdata[31:15] == '0 || m_axis_tdata[31:15] == '1) && (m_axis_tdata[63:47] == '0 || m_axis_tdata[63:47] == '1), "end word is not a raw sample")

endmodule

bind complex_block_decimator cbd_checker u_cbd_checker (.*);

`default_nettype wire
